### design/atss_pkg.sv
// Package for the table search and sort engine: request codes, status codes, sizes.
`default_nettype none
package atss_pkg;
   localparam int CAPACITY_DEFAULT = 128;
   localparam int WORD_W = 32;
   localparam int POS_W = 7;
   localparam int USED_W = 8;

   typedef enum logic [2:0] {
      REQ_APPEND  = 3'd0,
      REQ_UPDATE  = 3'd1,
      REQ_DELETE  = 3'd2,
      REQ_LSEARCH = 3'd3,
      REQ_BSEARCH = 3'd4,
      REQ_SORT    = 3'd5,
      REQ_READ    = 3'd6,
      REQ_NONE    = 3'd7
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_BADIDX = 2'd2,
      ST_MISS   = 2'd3
   } status_type;
endpackage
`default_nettype wire

### design/atss_cmp.sv
// Shared comparator: equality and signed less-than between a table word and an operand.
`default_nettype none
module atss_cmp
   import atss_pkg::*;
(
   input  wire logic [WORD_W-1:0] a,
   input  wire logic [WORD_W-1:0] b,
   output logic                   eq,
   output logic                   lt
);
   assign eq = (a == b);
   assign lt = ($signed(a) < $signed(b));
endmodule
`default_nettype wire

### design/array_table_search_sort.sv
// Top level of the table engine: request decode, sequencer and entry memory.
// The engine keeps CAPACITY signed 32-bit entries and a count of those in use.
// req_* carries one request item (kind, position, word); rsp_* returns one
// result item per request (status, found_at, word_out, used).
// One item is handled at a time; req_tready is low while a request is at work
// and while a result waits on the rsp side.
// Every entry access goes through a single memory port with a registered read,
// so the work of each request follows the number of reads:
//   append, update, unused code: no read used; read: one entry.
//   linear search: one read per entry examined.
//   binary search: one read per probe, log2(count)+1 probes at most.
//   delete: one read and one write per entry moved.
//   sort: n*(n-1)/2 compares of two reads each, plus two writes per swap.
// One comparator is shared by the searches and the sort.
// Reset clears the count and control state; entries are undefined until written.
// When the receiver stalls, the result stays on rsp_tdata and no new request
// is taken until it is accepted.
`default_nettype none
module array_table_search_sort
   import atss_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
)(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // req_tdata: req_type[2:0], position[9:3], word_in[41:10], zero fill [47:42]
   input  wire logic [47:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // rsp_tdata: status[1:0], found_at[8:2], word_out[40:9], used[48:41], zero [55:49]
   output logic [55:0]      rsp_tdata
);
   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = (CW > POS_W) ? CW : POS_W;

   typedef enum logic [3:0] {
      S_IDLE, S_DISPATCH, S_RD_WAIT, S_RD_DONE, S_LS_CHECK, S_BS_PROBE, S_BS_CHECK,
      S_DEL_WAIT, S_DEL_WRITE, S_SORT_RDA, S_SORT_RDB, S_SORT_CMP, S_SORT_WRB, S_DONE
   } state_type;

   state_type          state_ff;
   logic [WORD_W-1:0]  mem [CAPACITY];
   logic [WORD_W-1:0]  rdata_ff;
   logic [CW-1:0]      count_ff;
   logic [2:0]         kind_ff;
   logic [POS_W-1:0]   pos_ff;
   logic [WORD_W-1:0]  key_ff;
   logic [CW-1:0]      i_ff, j_ff;
   logic [CW:0]        lo_ff, hi_ff;
   logic [WORD_W-1:0]  hold_ff;
   status_type         status_ff;
   logic [POS_W-1:0]   at_ff;
   logic [WORD_W-1:0]  wout_ff;
   logic               rvalid_ff;

   logic               we;
   logic [AW-1:0]      waddr, raddr;
   logic [WORD_W-1:0]  wdata;
   logic [WORD_W-1:0]  cmp_b;
   logic               cmp_eq, cmp_lt;
   logic [CW:0]        mid;
   logic               pos_ok;

   atss_cmp u_cmp (.a(rdata_ff), .b(cmp_b), .eq(cmp_eq), .lt(cmp_lt));

   assign mid = (lo_ff + hi_ff) >> 1;
   assign cmp_b = (state_ff == S_SORT_CMP) ? hold_ff : key_ff;
   // The position is compared at full width so that a small table never aliases it.
   assign pos_ok = (PW'(pos_ff) < PW'(count_ff));

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   // Memory port control for the current state.
   always_comb begin
      we = 1'b0;
      waddr = '0;
      wdata = key_ff;
      raddr = i_ff[AW-1:0];
      case (state_ff)
         S_DISPATCH: begin
            if (kind_ff == REQ_APPEND && count_ff < CW'(CAPACITY)) begin
               we = 1'b1;
               waddr = count_ff[AW-1:0];
            end else if (kind_ff == REQ_UPDATE && pos_ok) begin
               we = 1'b1;
               waddr = AW'(pos_ff);
            end
            raddr = AW'(pos_ff);
         end
         S_BS_PROBE: raddr = mid[AW-1:0];
         S_DEL_WAIT: raddr = i_ff[AW-1:0];
         S_DEL_WRITE: begin
            we = 1'b1;
            waddr = AW'(i_ff - CW'(1));
            wdata = rdata_ff;
         end
         S_SORT_RDA: raddr = j_ff[AW-1:0];
         S_SORT_RDB: raddr = AW'(j_ff + CW'(1));
         S_SORT_CMP: begin
            // rdata holds entry j+1, hold holds entry j.
            if (cmp_lt) begin
               we = 1'b1;
               waddr = j_ff[AW-1:0];
               wdata = rdata_ff;
            end
         end
         S_SORT_WRB: begin
            we = 1'b1;
            waddr = AW'(j_ff);
            wdata = hold_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid && !rvalid_ff) begin
                  kind_ff   <= req_tdata[2:0];
                  pos_ff    <= req_tdata[9:3];
                  key_ff    <= req_tdata[41:10];
                  status_ff <= ST_OK;
                  at_ff     <= '0;
                  wout_ff   <= '0;
                  i_ff      <= '0;
                  j_ff      <= '0;
                  state_ff  <= S_DISPATCH;
               end
            end
            S_DISPATCH: begin
               state_ff <= S_DONE;
               case (kind_ff)
                  REQ_APPEND: begin
                     if (count_ff < CW'(CAPACITY)) count_ff <= count_ff + CW'(1);
                     else status_ff <= ST_FULL;
                  end
                  REQ_UPDATE: if (!pos_ok) status_ff <= ST_BADIDX;
                  REQ_READ: begin
                     if (!pos_ok) status_ff <= ST_BADIDX;
                     else begin
                        i_ff     <= CW'(pos_ff);
                        state_ff <= S_RD_WAIT;
                     end
                  end
                  REQ_DELETE: begin
                     if (!pos_ok) status_ff <= ST_BADIDX;
                     else begin
                        i_ff <= CW'(pos_ff) + CW'(1);
                        state_ff <= S_DEL_WAIT;
                     end
                  end
                  REQ_LSEARCH: begin
                     status_ff <= ST_MISS;
                     if (count_ff != '0) state_ff <= S_RD_WAIT;
                  end
                  REQ_BSEARCH: begin
                     status_ff <= ST_MISS;
                     lo_ff <= '0;
                     hi_ff <= {1'b0, count_ff} - (CW+1)'(1);
                     if (count_ff != '0) state_ff <= S_BS_PROBE;
                  end
                  REQ_SORT: begin
                     i_ff <= '0;
                     j_ff <= '0;
                     if (count_ff > CW'(1)) state_ff <= S_SORT_RDA;
                  end
                  default: ;
               endcase
            end
            S_RD_WAIT: state_ff <= (kind_ff == REQ_READ) ? S_RD_DONE : S_LS_CHECK;
            S_RD_DONE: begin
               wout_ff  <= rdata_ff;
               state_ff <= S_DONE;
            end
            S_LS_CHECK: begin
               if (cmp_eq) begin
                  status_ff <= ST_OK;
                  at_ff     <= POS_W'(i_ff);
                  state_ff  <= S_DONE;
               end else if (i_ff + CW'(1) >= count_ff) begin
                  state_ff <= S_DONE;
               end else begin
                  i_ff     <= i_ff + CW'(1);
                  state_ff <= S_RD_WAIT;
               end
            end
            S_BS_PROBE: begin
               i_ff     <= mid[CW-1:0];
               state_ff <= S_BS_CHECK;
            end
            S_BS_CHECK: begin
               if (cmp_eq) begin
                  status_ff <= ST_OK;
                  at_ff     <= POS_W'(i_ff);
                  state_ff  <= S_DONE;
               end else if (cmp_lt) begin
                  if ({1'b0, i_ff} + (CW+1)'(1) > hi_ff) state_ff <= S_DONE;
                  else begin
                     lo_ff    <= {1'b0, i_ff} + (CW+1)'(1);
                     state_ff <= S_BS_PROBE;
                  end
               end else begin
                  if ({1'b0, i_ff} == lo_ff) state_ff <= S_DONE;
                  else begin
                     hi_ff    <= {1'b0, i_ff} - (CW+1)'(1);
                     state_ff <= S_BS_PROBE;
                  end
               end
            end
            S_DEL_WAIT: begin
               if (i_ff >= count_ff) begin
                  count_ff <= count_ff - CW'(1);
                  state_ff <= S_DONE;
               end else state_ff <= S_DEL_WRITE;
            end
            S_DEL_WRITE: begin
               i_ff     <= i_ff + CW'(1);
               state_ff <= S_DEL_WAIT;
            end
            S_SORT_RDA: state_ff <= S_SORT_RDB;
            S_SORT_RDB: begin
               hold_ff  <= rdata_ff;
               state_ff <= S_SORT_CMP;
            end
            S_SORT_CMP: begin
               if (cmp_lt) begin
                  j_ff     <= j_ff + CW'(1);
                  state_ff <= S_SORT_WRB;
               end else if (j_ff + CW'(2) < count_ff - i_ff) begin
                  j_ff     <= j_ff + CW'(1);
                  state_ff <= S_SORT_RDA;
               end else if (i_ff + CW'(2) < count_ff) begin
                  i_ff     <= i_ff + CW'(1);
                  j_ff     <= '0;
                  state_ff <= S_SORT_RDA;
               end else state_ff <= S_DONE;
            end
            S_SORT_WRB: begin
               // j already advanced to the upper slot of the swapped pair.
               if (j_ff + CW'(1) < count_ff - i_ff) state_ff <= S_SORT_RDA;
               else if (i_ff + CW'(2) < count_ff) begin
                  i_ff     <= i_ff + CW'(1);
                  j_ff     <= '0;
                  state_ff <= S_SORT_RDA;
               end else state_ff <= S_DONE;
            end
            S_DONE: begin
               rvalid_ff <= 1'b1;
               state_ff  <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
         if (rvalid_ff && rsp_tready) rvalid_ff <= 1'b0;
      end
   end

   assign req_tready = (state_ff == S_IDLE) && !rvalid_ff;
   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = {7'd0, USED_W'(count_ff), wout_ff, at_ff, status_ff};
endmodule
`default_nettype wire

### verif/array_table_search_sort_test.sv
// Self-checking testbench for the table engine: random requests against a table predictor.
`default_nettype none
module array_table_search_sort_test
   import atss_pkg::*;
();

   localparam int CAP = CAPACITY_DEFAULT;

   typedef struct packed {
      status_type  status;
      logic [6:0]  found_at;
      logic [31:0] word_out;
      logic [7:0]  used;
   } table_answer_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;

   array_table_search_sort dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #5 clock = ~clock;

   logic [47:0]      pending_reqs[$];
   table_answer_type expected_answers[$];
   int               error_count = 0;

   // Predictor state.
   logic [31:0] table_words[CAP];
   int          table_used = 0;

   function automatic bit signed_less(logic [31:0] a, logic [31:0] b);
      return $signed(a) < $signed(b);
   endfunction

   function automatic table_answer_type apply_request(logic [47:0] item);
      req_kind_type     kind;
      int               pos;
      logic [31:0]      word;
      table_answer_type ans;
      int               lo, hi, mid;
      logic [31:0]      tmp;
      kind = req_kind_type'(item[2:0]);
      pos  = item[9:3];
      word = item[41:10];
      ans = '{status: ST_OK, found_at: '0, word_out: '0, used: '0};
      case (kind)
         REQ_APPEND: begin
            if (table_used >= CAP) ans.status = ST_FULL;
            else begin
               table_words[table_used] = word;
               table_used++;
            end
         end
         REQ_UPDATE: begin
            if (pos >= table_used) ans.status = ST_BADIDX;
            else table_words[pos] = word;
         end
         REQ_DELETE: begin
            if (pos >= table_used) ans.status = ST_BADIDX;
            else begin
               for (int i = pos; i + 1 < table_used; i++) table_words[i] = table_words[i + 1];
               table_used--;
            end
         end
         REQ_LSEARCH: begin
            ans.status = ST_MISS;
            for (int i = 0; i < table_used; i++) begin
               if (table_words[i] == word) begin
                  ans.status = ST_OK;
                  ans.found_at = 7'(i);
                  break;
               end
            end
         end
         REQ_BSEARCH: begin
            lo = 0;
            hi = table_used - 1;
            ans.status = ST_MISS;
            while (lo <= hi) begin
               mid = (lo + hi) / 2;
               if (table_words[mid] == word) begin
                  ans.status = ST_OK;
                  ans.found_at = 7'(mid);
                  break;
               end else if (signed_less(table_words[mid], word)) lo = mid + 1;
               else hi = mid - 1;
            end
         end
         REQ_SORT: begin
            for (int i = 0; i + 1 < table_used; i++)
               for (int j = 0; j + 1 < table_used - i; j++)
                  if (signed_less(table_words[j + 1], table_words[j])) begin
                     tmp = table_words[j];
                     table_words[j] = table_words[j + 1];
                     table_words[j + 1] = tmp;
                  end
         end
         REQ_READ: begin
            if (pos >= table_used) ans.status = ST_BADIDX;
            else ans.word_out = table_words[pos];
         end
         default: ;
      endcase
      ans.used = table_used[7:0];
      return ans;
   endfunction

   task automatic report(string field, logic [31:0] got, logic [31:0] want);
      error_count++;
      if (error_count <= 40)
         $display("mismatch on %s: got %0h, expected %0h", field, got, want);
   endtask

   // Sender: bursts of random length separated by random gaps.
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            req_tdata <= pending_reqs.pop_front();
            req_tvalid <= 1'b1;
            if (burst_left > 0) burst_left--;
            else begin
               burst_left = $urandom_range(0, 20);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: stall mode changes now and then; one long hold-off once the
   // random traffic is flowing, so that a result waits and the input stalls.
   int cycle_count = 0;
   int stall_mode = 0;
   int accepted_count = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count % 700 == 0) stall_mode = $urandom_range(0, 3);
      if (hold_left > 0) hold_left--;
      else if (!hold_done && accepted_count >= 400) begin
         hold_done = 1'b1;
         hold_left = 400;
      end
      if (hold_left > 0) rsp_tready <= 1'b0;
      else case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         2: rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= (cycle_count % 8 < 5);
      endcase
   end

   // Monitor: predict on request acceptance, check on result acceptance.
   always @(posedge clock) begin
      table_answer_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_answers.push_back(apply_request(req_tdata));
            accepted_count++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_answers.size() == 0) begin
               error_count++;
               $display("result with no request outstanding");
            end else begin
               want = expected_answers.pop_front();
               if (rsp_tdata[1:0] != want.status)
                  report("status", 32'(rsp_tdata[1:0]), 32'(want.status));
               if (rsp_tdata[8:2] != want.found_at)
                  report("found_at", 32'(rsp_tdata[8:2]), 32'(want.found_at));
               if (rsp_tdata[40:9] != want.word_out)
                  report("word_out", rsp_tdata[40:9], want.word_out);
               if (rsp_tdata[48:41] != want.used)
                  report("used", 32'(rsp_tdata[48:41]), 32'(want.used));
            end
         end
      end
   end

   // Generator side: a rough count of entries to steer positions and table size.
   int          gen_used = 0;
   logic [31:0] word_pool[16];

   function automatic void queue_item(req_kind_type kind, int pos, logic [31:0] word);
      pending_reqs.push_back({6'b0, word, pos[6:0], kind});
      case (kind)
         REQ_APPEND: if (gen_used < CAP) gen_used++;
         REQ_DELETE: if (pos < gen_used) gen_used--;
         default: ;
      endcase
   endfunction

   function automatic logic [31:0] pick_word();
      return ($urandom_range(0, 9) < 6) ? word_pool[$urandom_range(0, 15)] : $urandom();
   endfunction

   function automatic int pick_pos();
      if (gen_used > 0 && $urandom_range(0, 9) < 7) return $urandom_range(0, gen_used - 1);
      return $urandom_range(0, 127);
   endfunction

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_tvalid || expected_answers.size() != 0);
   endtask

   initial begin
      int target;
      int roll;
      foreach (word_pool[i]) word_pool[i] = $urandom();
      word_pool[0] = 32'h7fff_ffff;
      word_pool[1] = 32'h8000_0000;
      word_pool[2] = 32'h0;
      word_pool[3] = 32'hffff_ffff;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty-table cases, extremes, every request kind.
      queue_item(REQ_READ, 0, 0);
      queue_item(REQ_DELETE, 0, 0);
      queue_item(REQ_LSEARCH, 0, 5);
      queue_item(REQ_BSEARCH, 0, 5);
      queue_item(REQ_SORT, 0, 0);
      queue_item(REQ_APPEND, 0, 32'h7fff_ffff);
      queue_item(REQ_APPEND, 127, 32'h8000_0000);
      queue_item(REQ_APPEND, 0, 32'h0);
      queue_item(REQ_APPEND, 0, 32'hffff_ffff);
      queue_item(REQ_READ, 1, 0);
      queue_item(REQ_UPDATE, 2, 32'h5555_aaaa);
      queue_item(REQ_UPDATE, 127, 1);
      queue_item(REQ_READ, 127, 0);
      queue_item(REQ_LSEARCH, 0, 32'hffff_ffff);
      queue_item(REQ_BSEARCH, 0, 32'h8000_0000);
      queue_item(REQ_SORT, 0, 0);
      queue_item(REQ_BSEARCH, 0, 32'h7fff_ffff);
      queue_item(REQ_BSEARCH, 0, 32'h1234);
      queue_item(REQ_NONE, 127, 32'hffff_ffff);
      queue_item(REQ_DELETE, 0, 0);
      queue_item(REQ_DELETE, 4, 0);
      queue_item(REQ_READ, 0, 0);
      wait_idle();

      // Full table: fill, reject, sort, search, then drain most of it.
      while (gen_used < CAP) queue_item(REQ_APPEND, $urandom_range(0, 127), pick_word());
      queue_item(REQ_APPEND, 0, 1);
      queue_item(REQ_READ, 127, 0);
      queue_item(REQ_SORT, 0, 0);
      repeat (6) queue_item(REQ_BSEARCH, 0, pick_word());
      repeat (4) queue_item(REQ_LSEARCH, 0, pick_word());
      queue_item(REQ_DELETE, 127, 0);
      queue_item(REQ_DELETE, 0, 0);
      while (gen_used > 4) queue_item(REQ_DELETE, pick_pos(), 0);
      wait_idle();

      // Random sessions drifting toward a target size, mostly small tables.
      target = 6;
      for (int n = 0; n < 1350; n++) begin
         if (n % 60 == 0)
            target = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 128) : $urandom_range(1, 12);
         roll = $urandom_range(0, 99);
         if (roll < 3) queue_item(REQ_NONE, $urandom_range(0, 127), $urandom());
         else if (roll < 35)
            queue_item(gen_used < target ? REQ_APPEND : REQ_DELETE, pick_pos(), pick_word());
         else if (roll < 45) queue_item(REQ_UPDATE, pick_pos(), pick_word());
         else if (roll < 52) queue_item(REQ_DELETE, pick_pos(), 0);
         else if (roll < 66) queue_item(REQ_LSEARCH, 0, pick_word());
         else if (roll < 80) queue_item(REQ_BSEARCH, 0, pick_word());
         else if (roll < 88) queue_item(REQ_READ, pick_pos(), 0);
         else if (gen_used <= 32 || $urandom_range(0, 99) == 0) queue_item(REQ_SORT, 0, 0);
         else queue_item(REQ_READ, pick_pos(), 0);
         if (n == 700) wait_idle();
      end

      wait_idle();
      repeat (200) @(posedge clock);
      if (error_count == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

   initial begin
      #100000000;
      $display("Some tests failed");
      $finish;
   end
endmodule
`default_nettype wire
